// ===== rtl/pps_pkg.sv =====
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int ARR_W  = 16;
    localparam int BST_W  = 16;
    localparam int PRI_W  = 8;
    localparam int TIME_W = 21;
    localparam int CMD_W  = 2;
    localparam int SLOT_OUT_W = 4;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 112;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    // spare code, taken and ignored
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // Running best candidate handed from cell to cell during a scan.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [PRI_W-1:0] prio;
        logic [ARR_W-1:0] arrival;
        logic [BST_W-1:0] burst;
        logic [BST_W-1:0] remain;
    } t_tok;

endpackage

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// Top level of the preemptive priority scheduler: command decode, tick sequencing, result register.
//
// Tasks live in a chain of MAX_TASKS slot cells. A load request writes the next free slot and
// a clear request empties the table and sets time to zero. A tick request launches a candidate
// token into cell 0; it moves one cell per cycle, each cell folding in its own task if it has
// arrived, has work left and beats the token's priority (later arrival wins a tie, then the
// higher slot). Once the token leaves the last cell it is latched; then, as soon as the output
// register is free, the winner is charged one time unit, time advances (saturating) and the
// result is written into the output register. A tick therefore holds the block until the token
// has passed the whole cell chain and any earlier result held downstream has been taken. Loads
// and clears are taken while a result waits to be taken.
module preemptive_priority_scheduler_core
    import pps_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] arrival_time, [31:16] burst_length, [39:32] task_priority
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [3:0] ran_slot, [19:4] left_after, [20] finished, [41:21] completion_time,
    // [62:42] turnaround, [83:63] waiting, [104:84] now_time, [105] all_done, [111:106] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] ran_valid
    output logic                  m_axis_tuser
);

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    // Input request fields
    logic [ARR_W-1:0] w_arr;
    logic [BST_W-1:0] w_bst;
    logic [PRI_W-1:0] w_pri;
    logic             w_acc;
    logic             w_load;
    logic             w_clr;

    assign w_arr  = s_axis_tdata[15:0];
    assign w_bst  = s_axis_tdata[31:16];
    assign w_pri  = s_axis_tdata[39:32];
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_clr  = w_acc && (s_axis_tuser == CMD_CLEAR);

    t_state r_state;
    t_state n_state;
    logic   w_start;
    logic   w_commit;

    logic [CNT_W-1:0]  r_task_count;
    logic [TIME_W-1:0] r_time;
    logic              w_full;

    assign w_full = (r_task_count == CNT_W'(MAX_TASKS));
    assign w_load = w_acc && (s_axis_tuser == CMD_LOAD) && !w_full;

    // Token chain: index 0 is the launch point, index MAX_TASKS leaves the last cell.
    t_tok              w_tok  [0:MAX_TASKS];
    logic [SLOT_W-1:0] w_slot [0:MAX_TASKS];
    logic [CNT_W-1:0]  w_pend [0:MAX_TASKS];

    // valid is the top bit of the token; everything else starts empty
    assign w_tok[0]  = {w_start, {($bits(t_tok) - 1){1'b0}}};
    assign w_slot[0] = '0;
    assign w_pend[0] = '0;

    // Latched winner of the scan
    t_tok              r_b;
    logic [SLOT_W-1:0] r_b_slot;
    logic [CNT_W-1:0]  r_b_pend;

    logic w_upd;
    assign w_upd = w_commit && r_b.found;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            pps_cell #(
                .SLOT_W (SLOT_W),
                .CNT_W  (CNT_W),
                .IDX    (gi)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_clr      (w_clr),
                .i_wr       (w_load),
                .i_wr_slot  (r_task_count[SLOT_W-1:0]),
                .i_arr      (w_arr),
                .i_bst      (w_bst),
                .i_pri      (w_pri),
                .i_upd      (w_upd),
                .i_upd_slot (r_b_slot),
                .i_time     (r_time),
                .i_tok      (w_tok[gi]),
                .i_tok_slot (w_slot[gi]),
                .i_tok_pend (w_pend[gi]),
                .o_tok      (w_tok[gi+1]),
                .o_tok_slot (w_slot[gi+1]),
                .o_tok_pend (w_pend[gi+1])
            );
        end
    endgenerate

    // Sequencer: idle accepts requests, scan waits for the token, fin commits the tick.
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_start       = 1'b0;
        w_commit      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (s_axis_tuser == CMD_TICK)) begin
                    w_start = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tok[MAX_TASKS].valid) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Tick arithmetic on the latched winner
    logic [TIME_W-1:0]     w_ct;
    logic [BST_W-1:0]      w_left;
    logic                  w_fin;
    logic [TIME_W-1:0]     w_tat;
    logic [TIME_W-1:0]     w_bst_ext;
    logic [TIME_W-1:0]     w_wt;
    logic                  w_all_done;
    logic [SLOT_W+3:0]     w_slot_ext;
    logic [SLOT_OUT_W-1:0] w_slot_out;
    logic [BST_W-1:0]      w_left_out;
    logic [TIME_W-1:0]     w_ct_out;
    logic [TIME_W-1:0]     w_tat_out;
    logic [TIME_W-1:0]     w_wt_out;

    assign w_ct      = (r_time == TIME_MAX) ? r_time : r_time + TIME_W'(1);
    assign w_left    = r_b.remain - BST_W'(1);
    assign w_fin     = r_b.found && (w_left == '0);
    assign w_tat     = w_ct - {{(TIME_W-ARR_W){1'b0}}, r_b.arrival};
    assign w_bst_ext = {{(TIME_W-BST_W){1'b0}}, r_b.burst};
    assign w_wt      = (w_tat >= w_bst_ext) ? (w_tat - w_bst_ext) : '0;
    // pending count was taken before the charge; a finish removes the winner from it
    assign w_all_done = (r_b_pend == '0) || (w_fin && (r_b_pend == CNT_W'(1)));

    assign w_slot_ext = {4'b0000, r_b_slot};
    assign w_slot_out = r_b.found ? w_slot_ext[SLOT_OUT_W-1:0] : '0;
    assign w_left_out = r_b.found ? w_left : '0;
    assign w_ct_out   = w_fin ? w_ct  : '0;
    assign w_tat_out  = w_fin ? w_tat : '0;
    assign w_wt_out   = w_fin ? w_wt  : '0;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_task_count <= '0;
            r_time       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clr) begin
                r_task_count <= '0;
                r_time       <= '0;
            end else if (w_load) begin
                r_task_count <= r_task_count + CNT_W'(1);
            end else if (w_commit) begin
                r_time <= w_ct;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && w_tok[MAX_TASKS].valid) begin
            r_b      <= w_tok[MAX_TASKS];
            r_b_slot <= w_slot[MAX_TASKS];
            r_b_pend <= w_pend[MAX_TASKS];
        end
        if (w_commit) begin
            r_out_user <= r_b.found;
            r_out_data <= {6'b000000, w_all_done, w_ct, w_wt_out, w_tat_out, w_ct_out,
                           w_fin, w_left_out, w_slot_out};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ===== rtl/pps_cell.sv =====
// One task slot of the scheduler chain: holds the task and merges it into the passing token.
module pps_cell
    import pps_pkg::*;
#(
    parameter int SLOT_W = 4,
    parameter int CNT_W  = 5,
    parameter int IDX    = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr,
    input  logic              i_wr,
    input  logic [SLOT_W-1:0] i_wr_slot,
    input  logic [ARR_W-1:0]  i_arr,
    input  logic [BST_W-1:0]  i_bst,
    input  logic [PRI_W-1:0]  i_pri,
    input  logic              i_upd,
    input  logic [SLOT_W-1:0] i_upd_slot,
    input  logic [TIME_W-1:0] i_time,
    input  t_tok              i_tok,
    input  logic [SLOT_W-1:0] i_tok_slot,
    input  logic [CNT_W-1:0]  i_tok_pend,
    output t_tok              o_tok,
    output logic [SLOT_W-1:0] o_tok_slot,
    output logic [CNT_W-1:0]  o_tok_pend
);

    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

    logic             r_used;
    logic             r_done;
    logic [ARR_W-1:0] r_arr;
    logic [BST_W-1:0] r_bst;
    logic [BST_W-1:0] r_rem;
    logic [PRI_W-1:0] r_pri;

    t_tok              r_tok;
    t_tok              n_tok;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [CNT_W-1:0]  r_pend;
    logic [CNT_W-1:0]  n_pend;

    logic w_live;
    logic w_elig;
    logic w_take;

    assign w_live = r_used && !r_done;
    assign w_elig = w_live && ({{(TIME_W-ARR_W){1'b0}}, r_arr} <= i_time);
    // later arrival wins a priority tie; scan order makes the higher slot win a full tie
    assign w_take = w_elig && (!i_tok.found || (r_pri > i_tok.prio) ||
                    ((r_pri == i_tok.prio) && (r_arr >= i_tok.arrival)));

    always_comb begin
        n_tok  = i_tok;
        n_slot = i_tok_slot;
        n_pend = i_tok_pend + (w_live ? CNT_W'(1) : CNT_W'(0));
        if (w_take) begin
            n_tok.found   = 1'b1;
            n_tok.prio    = r_pri;
            n_tok.arrival = r_arr;
            n_tok.burst   = r_bst;
            n_tok.remain  = r_rem;
            n_slot        = MY_SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
            r_done <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_clr) begin
                r_used <= 1'b0;
                r_done <= 1'b0;
            end else if (i_wr && (i_wr_slot == MY_SLOT)) begin
                r_used <= 1'b1;
                r_done <= (i_bst == '0);
            end else if (i_upd && (i_upd_slot == MY_SLOT) && (r_rem == BST_W'(1))) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_pend <= n_pend;
        if (i_wr && (i_wr_slot == MY_SLOT)) begin
            r_arr <= i_arr;
            r_bst <= i_bst;
            r_rem <= i_bst;
            r_pri <= i_pri;
        end else if (i_upd && (i_upd_slot == MY_SLOT)) begin
            r_rem <= r_rem - BST_W'(1);
        end
    end

    assign o_tok      = r_tok;
    assign o_tok_slot = r_slot;
    assign o_tok_pend = r_pend;

endmodule

// ===== rtl/pps_chk.sv =====
// Port-level checker for the scheduler result stream, bound to the top level.
module pps_chk
    import pps_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[20:0] == '0))
        else $error("idle tick carries slot, remaining or finish");

    a_fin_times: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[20] |-> (m_axis_tdata[83:21] == '0))
        else $error("completion fields set without a finish");

    a_fin_now: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[20] |->
            m_axis_tuser && (m_axis_tdata[41:21] == m_axis_tdata[104:84]))
        else $error("finish without a run or with completion not equal to time");

endmodule

bind preemptive_priority_scheduler_core pps_chk u_pps_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
